[hw/rtl/assert_macros.svh]
// Assertion macros shared by the line crossing counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_n_s, cond, msg) \
	`ASSERT_AT(lbl, clk_s, rst_n_s, !(cond), msg)

`endif

[hw/rtl/lctc_pkg.sv]
// Shared types and constants of the line crossing track counter.
`timescale 1ns / 1ps
`default_nettype none

package lctc_pkg;

	// default number of track table slots
	localparam int TABLE_SLOTS_DEF = 64;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// one table entry in RAM: ident, last x, last y
	localparam int SLOT_W = 48;

	// input opcodes
	localparam logic [1:0] OP_TRACK = 2'd0;
	localparam logic [1:0] OP_EOF   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// classified request kinds
	localparam logic [1:0] CMD_FRESH = 2'd0;
	localparam logic [1:0] CMD_STALE = 2'd1;
	localparam logic [1:0] CMD_EOF   = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_END_X    = 3'd2;
	localparam logic [2:0] REG_END_Y    = 3'd3;
	localparam logic [2:0] REG_LINE_EN  = 3'd4;
	localparam logic [2:0] REG_ENTER    = 3'd5;
	localparam logic [2:0] REG_LOST_LIM = 3'd6;
	localparam logic [2:0] REG_RUN_EN   = 3'd7;

	// configuration register file
	typedef struct packed {
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic               line_enabled;
		logic        [1:0]  enter_side;
		logic        [7:0]  lost_limit;
		logic               run_enable;
	} cfg_t;

	// classified request carried through the queue
	typedef struct packed {
		logic        [1:0]  kind;
		logic        [15:0] ident;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} cmd_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

[hw/rtl/lctc_ram.sv]
// Generic single write, single read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lctc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/lctc_front.sv]
// Front end: accepts input requests and classifies them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module lctc_front import lctc_pkg::*; (
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // track_ident, frames_lost, pos_x, pos_y
	input  wire logic [1:0]  s_tuser,  // opcode
	input  wire cfg_t        cfg,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output cmd_t             push_data
);

	logic       accept;
	logic       keep;
	logic [1:0] kind;
	logic [7:0] frames_lost;

	assign s_tready    = !q_stat.full;
	assign accept      = s_tvalid && s_tready;
	assign frames_lost = s_tdata[23:16];

	// payload travels unchanged, only the kind is decided here (cmd_t order: kind, ident, x, y)
	assign push_data = {kind, s_tdata[15:0], s_tdata[39:24], s_tdata[55:40]};

	// a stopped counter, an invalid line for tracks and unknown opcodes drop the request
	always_comb begin
		keep = 1'b0;
		kind = CMD_EOF;
		unique case (s_tuser)
			OP_TRACK: begin
				keep = cfg.line_enabled;
				kind = (frames_lost > cfg.lost_limit) ? CMD_STALE : CMD_FRESH;
			end
			OP_EOF: begin
				keep = 1'b1;
				kind = CMD_EOF;
			end
			OP_CLEAR: begin
				keep = 1'b1;
				kind = CMD_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && cfg.run_enable && keep;

endmodule

`default_nettype wire

[hw/rtl/lctc_queue.sv]
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lctc_queue import lctc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	input  wire logic pop,
	output cmd_t      head,
	output q_stat_t   stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_NEVER(a_push_full, clk, arst_n, push && stat.full, "request pushed into full queue")
	`ASSERT_AT(a_count_range, clk, arst_n, count_q <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

`default_nettype wire

[hw/rtl/lctc_back.sv]
// Back end: table lookup, crossing test, frame bookkeeping and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lctc_back import lctc_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire q_stat_t     q_stat,
	input  wire cmd_t        cmd_in,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata   // entries_total, people_present, table_full
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_EXEC     = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_RESOLVE  = 3'd3;
	localparam logic [2:0] ST_SIDE_OLD = 3'd4;
	localparam logic [2:0] ST_SIDE_NEW = 3'd5;
	localparam logic [2:0] ST_DECIDE   = 3'd6;

	localparam logic [1:0] SGN_ZERO = 2'b00;
	localparam logic [1:0] SGN_POS  = 2'b01;
	localparam logic [1:0] SGN_NEG  = 2'b11;

	logic [2:0]             state_q;
	cmd_t                   cmd_q;

	// per-slot flags
	logic [TABLE_SLOTS-1:0] valid_q;
	logic [TABLE_SLOTS-1:0] counted_q;
	logic [TABLE_SLOTS-1:0] seen_q;

	// totals
	logic [31:0]            crossing_q;
	logic [15:0]            present_q;
	logic                   overflow_q;

	// scan control
	logic [IDX_W-1:0]       idx_q;
	logic                   issue_done_q;
	logic                   chk_vld_s1;
	logic [IDX_W-1:0]       chk_idx_s1;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   free_found_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic signed [15:0]     old_x_q;
	logic signed [15:0]     old_y_q;

	// side test
	logic signed [33:0]     p1_q;
	logic signed [33:0]     p2_q;
	logic [1:0]             s_old_q;

	// result register
	logic                   out_valid_q;
	logic [31:0]            out_entries_q;
	logic [15:0]            out_present_q;
	logic                   out_full_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [SLOT_W-1:0]      ram_wdata;
	logic [SLOT_W-1:0]      ram_rdata;
	logic [15:0]            rd_ident;
	logic signed [15:0]     rd_x;
	logic signed [15:0]     rd_y;
	logic                   chk_match;

	logic signed [16:0]     dx;
	logic signed [16:0]     dy;
	logic signed [15:0]     pt_x;
	logic signed [15:0]     pt_y;
	logic signed [16:0]     dpx;
	logic signed [16:0]     dpy;
	logic signed [33:0]     prod1;
	logic signed [33:0]     prod2;
	logic signed [34:0]     cp;
	logic [1:0]             cp_sign;
	logic [1:0]             dir;
	logic                   is_entry;
	logic                   eof_load;

	// id, x and y of every slot
	lctc_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	assign rd_ident  = ram_rdata[47:32];
	assign rd_x      = ram_rdata[31:16];
	assign rd_y      = ram_rdata[15:0];
	assign chk_match = chk_vld_s1 && valid_q[chk_idx_s1] && (rd_ident == cmd_q.ident);

	assign pop = (state_q == ST_IDLE) && !q_stat.empty;

	// new position goes to the hit slot, or to the lowest free slot for a new id
	assign ram_we    = (state_q == ST_RESOLVE) && (cmd_q.kind == CMD_FRESH)
		&& (hit_q || free_found_q);
	assign ram_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign ram_wdata = {cmd_q.ident, cmd_q.x, cmd_q.y};

	// cross product (E - S) x (P - S), one point per cycle
	assign dx    = {cfg.end_x[15], cfg.end_x} - {cfg.start_x[15], cfg.start_x};
	assign dy    = {cfg.end_y[15], cfg.end_y} - {cfg.start_y[15], cfg.start_y};
	assign pt_x  = (state_q == ST_SIDE_OLD) ? old_x_q : cmd_q.x;
	assign pt_y  = (state_q == ST_SIDE_OLD) ? old_y_q : cmd_q.y;
	assign dpx   = {pt_x[15], pt_x} - {cfg.start_x[15], cfg.start_x};
	assign dpy   = {pt_y[15], pt_y} - {cfg.start_y[15], cfg.start_y};
	assign prod1 = dx * dpy;
	assign prod2 = dy * dpx;
	assign cp    = {p1_q[33], p1_q} - {p2_q[33], p2_q};

	always_comb begin
		if (cp[34]) begin
			cp_sign = SGN_NEG;
		end else if (cp == '0) begin
			cp_sign = SGN_ZERO;
		end else begin
			cp_sign = SGN_POS;
		end
	end

	// both encodings with the top bit set count as negative
	always_comb begin
		case (cfg.enter_side)
			2'b00:   dir = SGN_ZERO;
			2'b01:   dir = SGN_POS;
			default: dir = SGN_NEG;
		endcase
	end

	assign is_entry = (s_old_q != SGN_ZERO) && (dir != SGN_ZERO) && (cp_sign == dir)
		&& (s_old_q != cp_sign);

	assign eof_load = (state_q == ST_EXEC) && (cmd_q.kind == CMD_EOF)
		&& (!out_valid_q || m_tready);

	// sequencer and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			counted_q    <= '0;
			seen_q       <= '0;
			crossing_q   <= '0;
			present_q    <= '0;
			overflow_q   <= 1'b0;
			idx_q        <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			s_old_q      <= SGN_ZERO;
			out_valid_q  <= 1'b0;
		end else begin
			if (eof_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					chk_vld_s1 <= 1'b0;
					unique case (cmd_q.kind) inside
						CMD_CLEAR: begin
							valid_q    <= '0;
							counted_q  <= '0;
							seen_q     <= '0;
							crossing_q <= '0;
							present_q  <= '0;
							overflow_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
						CMD_EOF: begin
							// report, drop unseen ids while the line is enabled, start a new frame
							if (eof_load) begin
								if (cfg.line_enabled) begin
									valid_q   <= valid_q & seen_q;
									counted_q <= counted_q & seen_q;
								end
								seen_q     <= '0;
								present_q  <= '0;
								overflow_q <= 1'b0;
								state_q    <= ST_IDLE;
							end
						end
						CMD_FRESH, CMD_STALE: begin
							idx_q        <= '0;
							issue_done_q <= 1'b0;
							hit_q        <= 1'b0;
							free_found_q <= 1'b0;
							state_q      <= ST_SCAN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					// check the slot read last cycle
					if (chk_vld_s1) begin
						if (chk_match) begin
							hit_q     <= 1'b1;
							hit_idx_q <= chk_idx_s1;
							state_q   <= ST_RESOLVE;
						end else begin
							if (!valid_q[chk_idx_s1] && !free_found_q) begin
								free_found_q <= 1'b1;
								free_idx_q   <= chk_idx_s1;
							end
							if (chk_idx_s1 == LAST_IDX) begin
								state_q <= ST_RESOLVE;
							end
						end
					end
					// issue the next read
					if (!issue_done_q) begin
						chk_vld_s1   <= 1'b1;
						issue_done_q <= (idx_q == LAST_IDX);
						if (idx_q != LAST_IDX) begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						chk_vld_s1 <= 1'b0;
					end
				end
				ST_RESOLVE: begin
					// an uncounted hit of a fresh track goes on to the side test
					if ((cmd_q.kind == CMD_FRESH) && hit_q && !counted_q[hit_idx_q]) begin
						state_q <= ST_SIDE_OLD;
					end else begin
						state_q <= ST_IDLE;
					end
					case (cmd_q.kind)
						CMD_STALE: begin
							if (hit_q) begin
								seen_q[hit_idx_q] <= 1'b1;
							end
						end
						CMD_FRESH: begin
							if (present_q != 16'hFFFF) begin
								present_q <= present_q + 1'b1;
							end
							if (hit_q) begin
								seen_q[hit_idx_q] <= 1'b1;
							end else if (free_found_q) begin
								valid_q[free_idx_q]   <= 1'b1;
								counted_q[free_idx_q] <= 1'b0;
								seen_q[free_idx_q]    <= 1'b1;
							end else begin
								overflow_q <= 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SIDE_OLD: begin
					state_q <= ST_SIDE_NEW;
				end
				ST_SIDE_NEW: begin
					s_old_q <= cp_sign;
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (is_entry) begin
						crossing_q           <= crossing_q + 1'b1;
						counted_q[hit_idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd_in;
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= idx_q;
		end
		if ((state_q == ST_SCAN) && chk_match) begin
			old_x_q <= rd_x;
			old_y_q <= rd_y;
		end
		if ((state_q == ST_SIDE_OLD) || (state_q == ST_SIDE_NEW)) begin
			p1_q <= prod1;
			p2_q <= prod2;
		end
		if (eof_load) begin
			out_entries_q <= crossing_q;
			out_present_q <= present_q;
			out_full_q    <= overflow_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_full_q, out_present_q, out_entries_q};

	`ASSERT_AT(a_counted_valid, clk, arst_n, (counted_q & ~valid_q) == '0, "counted slot not valid")
	`ASSERT_AT(a_seen_valid, clk, arst_n, (seen_q & ~valid_q) == '0, "seen slot not valid")
	`ASSERT_AT(a_cross_src, clk, arst_n, (crossing_q != $past(crossing_q)) |-> (($past(state_q) == ST_DECIDE) || (crossing_q == '0)), "entry count moved outside decision")

endmodule

`default_nettype wire

[hw/rtl/line_crossing_track_counter.sv]
// Top level of the line crossing track counter: config registers, front, queue, back.
//
//  channel  | direction | handshake             | contents
//  ---------+-----------+-----------------------+-------------------------------------------
//  s_*      | in        | s_tvalid / s_tready   | opcode in tuser; id, lost, x, y in tdata
//  m_*      | out       | m_tvalid / m_tready   | entries, present, table full (end of frame)
//  cfg_*    | in        | cfg_we, no wait       | register index and write data
//
// Track requests scan the slot RAM one entry a cycle: a hit ends the scan at its slot, a new id
// or a miss reads every slot, and an uncounted hit on a fresh track then goes on to the two cross
// products and the entry decision.
// The two-entry queue takes requests during a scan; s_tready drops once both entries are used.
// Reset clears all slot flags and totals at once; there is no sweep after reset.
// An end of frame waits while the previous result is pending and holds the requests behind it.
`timescale 1ns / 1ps
`default_nettype none

module line_crossing_track_counter import lctc_pkg::*; #(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // track_ident, frames_lost, pos_x, pos_y
	input  wire logic [1:0]  s_tuser,   // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // entries_total, people_present, table_full
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push;
	cmd_t    push_data;
	logic    pop;
	cmd_t    head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_x      <= '0;
			cfg_q.start_y      <= '0;
			cfg_q.end_x        <= '0;
			cfg_q.end_y        <= '0;
			cfg_q.line_enabled <= 1'b0;
			cfg_q.enter_side   <= 2'd1;
			cfg_q.lost_limit   <= 8'd5;
			cfg_q.run_enable   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:  cfg_q.start_x      <= cfg_data;
				REG_START_Y:  cfg_q.start_y      <= cfg_data;
				REG_END_X:    cfg_q.end_x        <= cfg_data;
				REG_END_Y:    cfg_q.end_y        <= cfg_data;
				REG_LINE_EN:  cfg_q.line_enabled <= cfg_data[0];
				REG_ENTER:    cfg_q.enter_side   <= cfg_data[1:0];
				REG_LOST_LIM: cfg_q.lost_limit   <= cfg_data[7:0];
				REG_RUN_EN:   cfg_q.run_enable   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	lctc_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	lctc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	lctc_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.cmd_in   (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
